FILE: src/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared constants for the sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

    localparam int unsigned WINDOW_DEF      = 5;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

endpackage

`default_nettype wire

FILE: src/sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Running median over the last WINDOW signed samples (lower median if even).
// ----------------------------------------------------------------------------
// the median is registered and shown on the output in the cycle after its sample is accepted
// throughput: one sample per cycle while the output is not stalled; the sorted window updates in one pass
// no median is produced until WINDOW samples have arrived
// reset clears the fill count, ring pointer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_filter #(
    parameter int unsigned WINDOW      = swmf_pkg::WINDOW_DEF,
    parameter int unsigned SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,  // sample
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [DATA_W-1:0] m_axis_tdata   // median
);

    import swmf_pkg::*;

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned PTR_W = $clog2(WINDOW);
    localparam int unsigned MID   = (WINDOW - 1) / 2;

    logic [SAMPLE_BITS-1:0]             r_ring [WINDOW];
    logic [WINDOW-1:0][SAMPLE_BITS-1:0] r_sorted;
    logic [WINDOW-1:0][SAMPLE_BITS-1:0] n_sorted;
    logic [PTR_W-1:0]                   r_ptr;
    logic [PTR_W-1:0]                   n_ptr;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic                               r_valid;
    logic                               n_valid;
    logic [SAMPLE_BITS-1:0]             r_median;
    logic [SAMPLE_BITS-1:0]             sample;
    logic                               accept;
    logic                               emit;

    assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = accept && (r_count >= CNT_W'(WINDOW - 1));

    swmf_sorter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_sorter (
        .i_sorted (r_sorted),
        .i_count  (r_count),
        .i_oldest (r_ring[r_ptr]),
        .i_sample (sample),
        .o_sorted (n_sorted)
    );

    always_comb begin
        n_ptr   = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
        n_count = (r_count == CNT_W'(WINDOW)) ? r_count : r_count + 1'b1;
        n_valid = emit ? 1'b1 : (m_axis_tready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_ptr   <= n_ptr;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_ptr] <= sample;
            r_sorted      <= n_sorted;
        end
        if (emit) begin
            r_median <= n_sorted[MID];
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = DATA_W'(r_median);

endmodule

`default_nettype wire

FILE: src/swmf_sorter.sv
// ----------------------------------------------------------------------------
// swmf_sorter
// Sorted window update: drops one copy of the oldest sample from the sorted
// list once the window is full, then inserts the new sample in place.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_sorter #(
    parameter int unsigned WINDOW      = swmf_pkg::WINDOW_DEF,
    parameter int unsigned SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned CNT_W       = $clog2(WINDOW + 1)
) (
    input  wire logic [WINDOW-1:0][SAMPLE_BITS-1:0] i_sorted,
    input  wire logic [CNT_W-1:0]                   i_count,
    input  wire logic [SAMPLE_BITS-1:0]             i_oldest,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample,
    output logic      [WINDOW-1:0][SAMPLE_BITS-1:0] o_sorted
);

    logic                               full;
    logic [WINDOW-2:0][SAMPLE_BITS-1:0] rem;
    logic [WINDOW-2:0]                  gt;

    assign full = (i_count == CNT_W'(WINDOW));

    // removal: entries below the oldest value stay, the rest move down
    for (genvar i = 0; i < WINDOW - 1; i++) begin : g_rem
        logic below;
        logic valid;
        assign below = $signed(i_sorted[i]) < $signed(i_oldest);
        assign rem[i] = (full && !below) ? i_sorted[i+1] : i_sorted[i];
        assign valid = full || (CNT_W'(i) < i_count);
        assign gt[i] = !valid || ($signed(rem[i]) > $signed(i_sample));
    end

    // insertion: entries above the new sample move up one place
    assign o_sorted[0] = gt[0] ? i_sample : rem[0];
    for (genvar i = 1; i < WINDOW - 1; i++) begin : g_ins
        assign o_sorted[i] = !gt[i]     ? rem[i]   :
                             !gt[i-1]   ? i_sample : rem[i-1];
    end
    assign o_sorted[WINDOW-1] = !gt[WINDOW-2] ? i_sample : rem[WINDOW-2];

endmodule

`default_nettype wire

FILE: src/swmf_checker.sv
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks for the sliding window median filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_checker #(
    parameter int unsigned SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata
);

    import swmf_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted sample");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata >> SAMPLE_BITS) == '0))
        else $error("padding bits set in output beat");

endmodule

bind sliding_window_median_filter swmf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DATA_W      (DATA_W)
) u_swmf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window median filter. Samples stream in
// on the slave side with random gaps while the master side stalls at random.
// A scoreboard keeps its own arrival ring and ascending copy of the window,
// predicts the median for every sample once the window is full, and compares
// each output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    localparam int WIN        = WINDOW_DEF;
    localparam int SW         = SAMPLE_BITS_DEF;
    localparam int DW         = ((SW + 7) / 8) * 8;
    localparam int N_RANDOM   = 1400;
    localparam int IDLE_LIMIT = 4000;

    typedef logic signed [SW-1:0] sample_t;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata  = '0;  // sample
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;        // median

    bit      steady = 1'b0;
    sample_t last_sample = '0;

    sliding_window_median_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    class median_scoreboard;
        sample_t     arrival[WIN];
        sample_t     ranked[WIN];
        int unsigned head;
        int unsigned held;
        sample_t     medians[$];
        int unsigned errors;

        function new();
            foreach (arrival[k]) begin
                arrival[k] = '0;
                ranked[k]  = '0;
            end
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return medians.size();
        endfunction

        function void rank_insert(int unsigned n, sample_t s);
            int unsigned i;
            i = n;
            while (i > 0 && ranked[i-1] > s) begin
                ranked[i] = ranked[i-1];
                i--;
            end
            ranked[i] = s;
        endfunction

        function void rank_remove(sample_t s);
            int unsigned at;
            at = WIN - 1;
            for (int i = 0; i < WIN; i++) begin
                if (ranked[i] == s) begin
                    at = i;
                    break;
                end
            end
            for (int i = at; i + 1 < WIN; i++) begin
                ranked[i] = ranked[i+1];
            end
        endfunction

        function void note_sample(logic [DW-1:0] raw);
            sample_t s;
            s = raw[SW-1:0];
            if (held < WIN) begin
                rank_insert(held, s);
                held++;
            end else begin
                rank_remove(arrival[head]);
                rank_insert(WIN - 1, s);
            end
            arrival[head] = s;
            head = (head + 1) % WIN;
            if (held == WIN) begin
                medians.push_back(ranked[(WIN - 1) / 2]);
            end
        endfunction

        function void check_median(logic [DW-1:0] raw);
            sample_t got;
            sample_t want;
            got = raw[SW-1:0];
            if (medians.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: unexpected median beat %0d", got);
                end
            end else begin
                want = medians.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("tb: median mismatch expected %0d actual %0d", want, got);
                    end
                end
            end
        endfunction
    endclass

    median_scoreboard sb = new();

    initial begin
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) begin
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function sample_t pick_sample();
        int      kind;
        sample_t v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: v = sample_t'($urandom);
            4, 5, 6:    v = sample_t'(int'($urandom_range(0, 8)) - 4);
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(SW-1){1'b0}}};
                    1:       v = {1'b0, {(SW-1){1'b1}}};
                    2:       v = {1'b1, {(SW-2){1'b0}}, 1'b1};
                    default: v = {1'b0, {(SW-2){1'b1}}, 1'b0};
                endcase
            end
            8:       v = last_sample;
            default: v = last_sample + sample_t'(int'($urandom_range(0, 6)) - 3);
        endcase
        return v;
    endfunction

    task automatic send_sample(input sample_t v, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(v);
        last_sample   = v;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain_medians();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // master side backpressure
    initial begin
        int gap;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_sample(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_median(m_axis_tdata);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int directed[];
        directed = '{
            0, -32768, 32767, -1, 1,
            7, 7, 7, 7, 7,
            7, -32768, 32767, -32768, 32767,
            1, 2, 3, 4, 5,
            5, 4, 3, 2, 1
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_sample(sample_t'(directed[k]), (k % 3 == 0) ? 0 : pick_gap());
        end

        // hold off until the filter has delivered everything
        drain_medians();

        for (int n = 0; n < N_RANDOM; n++) begin
            steady = ((n / 100) % 4 == 1);
            send_sample(pick_sample(), pick_gap());
        end
        steady = 1'b0;

        drain_medians();
        repeat (4) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
